FILE: rtl/core/nspt_pkg.sv
// ----------------------------------------------------------------------------
// nspt_pkg
// Shared types, codes and constants of the nearest slot position tracker.
// ----------------------------------------------------------------------------
package nspt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam int POS_W   = 32;
   localparam int SCALE_W = 24;
   localparam int DIST_W  = 64;
   localparam int THR_W   = 40;
   localparam int TOL_W   = 16;
   localparam int HOLD_W  = 8;
   localparam int REJ_W   = 32;
   localparam int IDX_W   = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 40'd11468800;
   localparam logic [TOL_W-1:0]  TIE_RESET       = 16'd66;
   localparam logic [HOLD_W-1:0] HOLD_RESET      = 8'd5;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_TIE       = 2'd1,
      REG_HOLD      = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_MATCHED  = 2'd0,
      ST_NEW      = 2'd1,
      ST_REJECTED = 2'd2,
      ST_TICK     = 2'd3
   } status_type;

   typedef enum logic {
      KIND_OBSERVE = 1'b0,
      KIND_TICK    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [SCALE_W-1:0] scale_sum;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  slot_index;
      logic [REJ_W-1:0]  rejects_total;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0]  threshold_sq;
      logic [TOL_W-1:0]  tie_tolerance_sq;
      logic [HOLD_W-1:0] hold_frames;
   } cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [SCALE_W-1:0] scale_sum;
   } q_entry_type;

endpackage

FILE: rtl/core/nearest_slot_position_tracker.sv
// ----------------------------------------------------------------------------
// nearest_slot_position_tracker
// Matches observed 3-D positions to a table of aging slots.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; up to
// QDEPTH beats wait in a queue, and busy is high while it is full. For an
// observe beat the slot engine squares one axis of one slot per cycle in its
// single 32x32 squarer, then drains a four-stage pipeline before it updates
// the table. A tick beat needs no scan. Every beat gives one result, shown
// on rsp_payload for exactly one cycle with rsp_strobe; the receiver cannot
// hold it off, so it must take every strobe. The slot table is empty after
// reset with no clearing pass. The user must write configuration through the
// APB-style port while no beat is in flight; the block does not enforce this.
module nearest_slot_position_tracker
   import nspt_pkg::*;
#(
   parameter int SLOTS  = SLOTS_DEFAULT,
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type     cfg;
   logic        q_valid;
   logic        q_pop;
   q_entry_type q_entry;

   nspt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nspt_front #(
      .DEPTH (QDEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   nspt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/nspt_ram.sv
// ----------------------------------------------------------------------------
// nspt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nspt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/nspt_csr.sv
// ----------------------------------------------------------------------------
// nspt_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module nspt_csr
   import nspt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[4:3]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_THRESHOLD: cfg_in.threshold_sq     = pwdata[THR_W-1:0];
            REG_TIE:       cfg_in.tie_tolerance_sq = pwdata[TOL_W-1:0];
            REG_HOLD:      cfg_in.hold_frames      = pwdata[HOLD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.threshold_sq);
         REG_TIE:       prdata = CSR_DATA_W'(cfg_ff.tie_tolerance_sq);
         REG_HOLD:      prdata = CSR_DATA_W'(cfg_ff.hold_frames);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_sq     <= THRESHOLD_RESET;
         cfg_ff.tie_tolerance_sq <= TIE_RESET;
         cfg_ff.hold_frames      <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/nspt_front.sv
// ----------------------------------------------------------------------------
// nspt_front
// Takes command beats, tags them as observe or tick and queues them for the
// slot engine.
// ----------------------------------------------------------------------------
module nspt_front
   import nspt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_payload,
   output logic        busy,
   output logic        q_valid,
   output q_entry_type q_entry,
   input  logic        q_pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   q_entry_type     entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   q_entry_type     new_entry;

   assign busy    = (count_ff == FullCnt);
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      new_entry.kind      = req_payload.cmd ? KIND_TICK : KIND_OBSERVE;
      new_entry.pos_x     = req_payload.pos_x;
      new_entry.pos_y     = req_payload.pos_y;
      new_entry.pos_z     = req_payload.pos_z;
      new_entry.scale_sum = req_payload.scale_sum;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: rtl/core/nspt_back.sv
// ----------------------------------------------------------------------------
// nspt_back
// Slot engine: scans the slot table one axis per cycle through a shared
// squarer, picks the nearest slot, updates the table and issues the result.
// ----------------------------------------------------------------------------
module nspt_back
   import nspt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  q_entry_type q_entry,
   output logic        q_pop,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload
);

   localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IdxW  = (SlotW > IDX_W) ? SlotW : IDX_W;
   localparam int RamW  = 3 * POS_W + SCALE_W;
   localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_DRAIN = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   q_entry_type    cur_ff;

   logic [HOLD_W-1:0] hold_ff [SLOTS];
   logic [HOLD_W-1:0] hold_in [SLOTS];
   logic [REJ_W-1:0]  reject_ff, reject_in;

   // scan issue counters
   logic [SlotW-1:0] scan_slot_ff, scan_slot_in;
   axis_type         scan_axis_ff, scan_axis_in;
   logic             issue;

   // stage 1: ram data arrives
   logic             p1_vld_ff;
   logic [SlotW-1:0] p1_slot_ff;
   axis_type         p1_axis_ff;

   // stage 2: axis magnitude
   logic               p2_vld_ff;
   logic [SlotW-1:0]   p2_slot_ff;
   axis_type           p2_axis_ff;
   logic [POS_W-1:0]   p2_mag_ff;
   logic [SCALE_W-1:0] p2_sdiff_ff;
   logic               p2_live_ff;

   // stage 3: square
   logic               p3_vld_ff;
   logic [SlotW-1:0]   p3_slot_ff;
   axis_type           p3_axis_ff;
   logic [DIST_W-1:0]  p3_sq_ff;
   logic [SCALE_W-1:0] p3_sdiff_ff;
   logic               p3_live_ff;
   logic [DIST_W-1:0]  acc_ff;

   // stage 4: full distance, compare
   logic               p4_vld_ff;
   logic [SlotW-1:0]   p4_slot_ff;
   logic [DIST_W-1:0]  p4_dist_ff;
   logic [SCALE_W-1:0] p4_sdiff_ff;
   logic               p4_live_ff;

   logic               best_found_ff, best_found_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [SCALE_W-1:0] best_sdiff_ff, best_sdiff_in;
   logic [SlotW-1:0]   best_slot_ff, best_slot_in;
   logic               free_found_ff, free_found_in;
   logic [SlotW-1:0]   free_slot_ff, free_slot_in;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic [RamW-1:0] rd_data;
   logic            wr_en;
   logic [SlotW-1:0] wr_addr;

   logic signed [POS_W-1:0]   rd_x, rd_y, rd_z, sel_a, sel_b;
   logic signed [SCALE_W-1:0] rd_s;
   logic [POS_W:0]            axis_diff, axis_abs;
   logic [SCALE_W:0]          scale_diff, scale_abs;
   logic                      p1_live;

   logic [DIST_W:0]   acc_ext;
   logic [DIST_W-1:0] acc_sat, acc_sum;

   logic              cand, better;
   logic [DIST_W-1:0] thr_ext, tol_ext;

   logic             pipe_empty;
   status_type       fin_status;
   logic [SlotW-1:0] fin_slot;
   logic [IdxW-1:0]  idx_wide;

   nspt_ram #(
      .WIDTH (RamW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({cur_ff.pos_x, cur_ff.pos_y, cur_ff.pos_z, cur_ff.scale_sum}),
      .rd_addr (scan_slot_ff),
      .rd_data (rd_data)
   );

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign issue = (state_ff == S_SCAN);

   // ---- stage 1: magnitude of one axis, scale difference ----
   assign rd_x = rd_data[RamW-1 -: POS_W];
   assign rd_y = rd_data[RamW-POS_W-1 -: POS_W];
   assign rd_z = rd_data[SCALE_W+POS_W-1 -: POS_W];
   assign rd_s = rd_data[SCALE_W-1:0];

   always_comb begin
      case (p1_axis_ff)
         AXIS_X: begin
            sel_a = cur_ff.pos_x;
            sel_b = rd_x;
         end
         AXIS_Y: begin
            sel_a = cur_ff.pos_y;
            sel_b = rd_y;
         end
         default: begin
            sel_a = cur_ff.pos_z;
            sel_b = rd_z;
         end
      endcase
   end

   assign axis_diff  = {sel_a[POS_W-1], sel_a} - {sel_b[POS_W-1], sel_b};
   assign axis_abs   = axis_diff[POS_W] ? ((POS_W+1)'(0) - axis_diff) : axis_diff;
   assign scale_diff = {cur_ff.scale_sum[SCALE_W-1], cur_ff.scale_sum}
                     - {rd_s[SCALE_W-1], rd_s};
   assign scale_abs  = scale_diff[SCALE_W] ? ((SCALE_W+1)'(0) - scale_diff) : scale_diff;
   assign p1_live    = (hold_ff[p1_slot_ff] != '0);

   // ---- stage 3: saturating accumulate over the three axes ----
   assign acc_ext = {1'b0, acc_ff} + {1'b0, p3_sq_ff};
   assign acc_sat = acc_ext[DIST_W] ? '1 : acc_ext[DIST_W-1:0];
   assign acc_sum = (p3_axis_ff == AXIS_X) ? p3_sq_ff : acc_sat;

   // ---- stage 4: candidate test and best selection ----
   assign thr_ext = DIST_W'(cfg.threshold_sq);
   assign tol_ext = DIST_W'(cfg.tie_tolerance_sq);
   assign cand    = p4_vld_ff && p4_live_ff && (p4_dist_ff <= thr_ext);

   always_comb begin
      if (!best_found_ff) begin
         better = 1'b1;
      end else if ((p4_dist_ff < tol_ext) && (best_dist_ff < tol_ext)) begin
         // both practically at the same spot: scale decides
         better = (p4_sdiff_ff < best_sdiff_ff);
      end else begin
         better = (p4_dist_ff < best_dist_ff);
      end
   end

   assign pipe_empty = !p1_vld_ff && !p2_vld_ff && !p3_vld_ff && !p4_vld_ff;

   always_comb begin
      if (best_found_ff) begin
         fin_status = ST_MATCHED;
         fin_slot   = best_slot_ff;
      end else if (free_found_ff) begin
         fin_status = ST_NEW;
         fin_slot   = free_slot_ff;
      end else begin
         fin_status = ST_REJECTED;
         fin_slot   = '0;
      end
   end

   assign idx_wide = IdxW'(fin_slot);

   // ---- control ----
   always_comb begin
      state_in      = state_ff;
      scan_slot_in  = scan_slot_ff;
      scan_axis_in  = scan_axis_ff;
      reject_in     = reject_ff;
      best_found_in = best_found_ff;
      best_dist_in  = best_dist_ff;
      best_sdiff_in = best_sdiff_ff;
      best_slot_in  = best_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = fin_slot;
      for (int i = 0; i < SLOTS; i++) begin
         hold_in[i] = hold_ff[i];
      end

      if (cand && better) begin
         best_found_in = 1'b1;
         best_dist_in  = p4_dist_ff;
         best_sdiff_in = p4_sdiff_ff;
         best_slot_in  = p4_slot_ff;
      end
      // lowest free slot, found in scan order
      if (p4_vld_ff && !p4_live_ff && !free_found_ff) begin
         free_found_in = 1'b1;
         free_slot_in  = p4_slot_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_entry.kind == KIND_TICK) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (hold_ff[i] != '0) begin
                        hold_in[i] = hold_ff[i] - 1'b1;
                     end
                  end
                  rsp_strobe_in        = 1'b1;
                  rsp_in.status        = ST_TICK;
                  rsp_in.slot_index    = '0;
                  rsp_in.rejects_total = reject_ff;
               end else begin
                  state_in      = S_SCAN;
                  scan_slot_in  = '0;
                  scan_axis_in  = AXIS_X;
                  best_found_in = 1'b0;
                  free_found_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            case (scan_axis_ff)
               AXIS_X:  scan_axis_in = AXIS_Y;
               AXIS_Y:  scan_axis_in = AXIS_Z;
               default: begin
                  scan_axis_in = AXIS_X;
                  if (scan_slot_ff == LastSlot) begin
                     state_in = S_DRAIN;
                  end else begin
                     scan_slot_in = scan_slot_ff + 1'b1;
                  end
               end
            endcase
         end
         S_DRAIN: begin
            if (pipe_empty) begin
               state_in             = S_IDLE;
               rsp_strobe_in        = 1'b1;
               rsp_in.status        = fin_status;
               rsp_in.slot_index    = idx_wide[IDX_W-1:0];
               if (fin_status == ST_REJECTED) begin
                  if (reject_ff != '1) begin
                     reject_in = reject_ff + 1'b1;
                  end
               end else begin
                  wr_en            = 1'b1;
                  hold_in[fin_slot] = cfg.hold_frames;
               end
               rsp_in.rejects_total = reject_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         reject_ff     <= '0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         p3_vld_ff     <= 1'b0;
         p4_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         scan_slot_ff  <= '0;
         scan_axis_ff  <= AXIS_X;
         for (int i = 0; i < SLOTS; i++) begin
            hold_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         reject_ff     <= reject_in;
         p1_vld_ff     <= issue;
         p2_vld_ff     <= p1_vld_ff;
         p3_vld_ff     <= p2_vld_ff;
         p4_vld_ff     <= p3_vld_ff && (p3_axis_ff == AXIS_Z);
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_slot_ff  <= scan_slot_in;
         scan_axis_ff  <= scan_axis_in;
         for (int i = 0; i < SLOTS; i++) begin
            hold_ff[i] <= hold_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      p1_slot_ff    <= scan_slot_ff;
      p1_axis_ff    <= scan_axis_ff;
      p2_slot_ff    <= p1_slot_ff;
      p2_axis_ff    <= p1_axis_ff;
      p2_mag_ff     <= axis_abs[POS_W-1:0];
      p2_sdiff_ff   <= scale_abs[SCALE_W-1:0];
      p2_live_ff    <= p1_live;
      p3_slot_ff    <= p2_slot_ff;
      p3_axis_ff    <= p2_axis_ff;
      p3_sq_ff      <= p2_mag_ff * p2_mag_ff;
      p3_sdiff_ff   <= p2_sdiff_ff;
      p3_live_ff    <= p2_live_ff;
      if (p3_vld_ff) begin
         acc_ff <= acc_sum;
      end
      p4_slot_ff    <= p3_slot_ff;
      p4_dist_ff    <= acc_sum;
      p4_sdiff_ff   <= p3_sdiff_ff;
      p4_live_ff    <= p3_live_ff;
      best_dist_ff  <= best_dist_in;
      best_sdiff_ff <= best_sdiff_in;
      best_slot_ff  <= best_slot_in;
      free_slot_ff  <= free_slot_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
